// ----- hw/rtl/cppm_pkg.sv -----
// ----------------------------------------------------------------------------
// cppm_pkg
// shared constants for the cppm frame decoder: channel count, burst size,
// field widths, reset widths and configuration register indexes
// ----------------------------------------------------------------------------
package cppm_pkg;

  // channels tracked per frame (1 to 8)
  localparam int CHANNELS    = 8;
  localparam int MAX_BURST   = 8;
  localparam int BURST       = (CHANNELS < MAX_BURST) ? CHANNELS : MAX_BURST;

  localparam int POS_W       = $clog2(CHANNELS + 1);
  localparam int CHAN_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BURST_W     = (BURST > 1) ? $clog2(BURST) : 1;

  localparam int TIME_W      = 32;
  localparam int WIDTH_W     = 16;
  localparam int CHANNEL_W   = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 16'd1500;

  localparam logic [WIDTH_W-1:0] RESET_MIN_PULSE  = 16'd700;
  localparam logic [WIDTH_W-1:0] RESET_MAX_PULSE  = 16'd2250;
  localparam logic [WIDTH_W-1:0] RESET_SYNC_PULSE = 16'd2700;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PULSE = 2'd2;

endpackage

// ----- hw/rtl/cppm_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// cppm_frame_decoder
// decodes cppm/ppm pulse-position frames from edge timestamps and emits the
// held channel widths as a burst on every frame sync
// ----------------------------------------------------------------------------
// sequencing: an edge beat is decided after ST_DIFF, ST_CMP_MIN, ST_CMP_MAX,
//   ST_CMP_SYNC and ST_UPDATE; a sync edge then enters ST_EMIT for its beats
// throughput: no new edge is taken until the sequencer is back in idle, the
//   shared subtractor doing the interval and the three threshold compares in
//   turn; a sync edge adds one channel beat per cycle (8) while not stalled
// reset: synchronous; thresholds return to 700/2250/2700, all widths to 1500,
//   error count, channel position and previous edge time to zero
module cppm_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_write,
  input  logic [cppm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cppm_pkg::WIDTH_W-1:0]       cfg_data,
  // edge beats
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cppm_pkg::TIME_W-1:0]        time_us,
  // channel beats
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cppm_pkg::CHANNEL_W-1:0]     channel,
  output logic [cppm_pkg::WIDTH_W-1:0]       width_us,
  output logic                               last,
  output logic                               frame_good,
  output logic [cppm_pkg::WIDTH_W-1:0]       error_count
);

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DIFF     = 7'b0000010,
    ST_CMP_MIN  = 7'b0000100,
    ST_CMP_MAX  = 7'b0001000,
    ST_CMP_SYNC = 7'b0010000,
    ST_UPDATE   = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [cppm_pkg::WIDTH_W-1:0] min_pulse_us;
  logic [cppm_pkg::WIDTH_W-1:0] max_pulse_us;
  logic [cppm_pkg::WIDTH_W-1:0] sync_pulse_us;

  // decoder state
  logic [cppm_pkg::TIME_W-1:0]  previous_edge_time;
  logic [cppm_pkg::POS_W-1:0]   channel_position;
  logic                         poisoned;
  logic [cppm_pkg::WIDTH_W-1:0] pending_widths [cppm_pkg::CHANNELS];
  logic [cppm_pkg::WIDTH_W-1:0] held_widths    [cppm_pkg::CHANNELS];
  logic [cppm_pkg::WIDTH_W-1:0] bad_interval_count;

  // per-edge working registers (payload, no reset, but for emit_idx)
  logic [cppm_pkg::TIME_W-1:0]  edge_time;
  logic [cppm_pkg::TIME_W-1:0]  interval;
  logic                         lt_min;
  logic                         gt_max;
  logic                         lt_sync;
  logic                         burst_good;
  logic [cppm_pkg::BURST_W-1:0] emit_idx;

  // shared subtractor: borrow out gives a < b
  logic [cppm_pkg::TIME_W-1:0]  sub_a;
  logic [cppm_pkg::TIME_W-1:0]  sub_b;
  logic [cppm_pkg::TIME_W:0]    sub_res;
  logic                         sub_borrow;

  // decision terms
  logic                         bad;
  logic                         poisoned_next;
  logic                         out_free;

  always_comb begin
    sub_a = interval;
    sub_b = cppm_pkg::TIME_W'(sync_pulse_us);
    unique case (state)
      ST_DIFF: begin
        sub_a = edge_time;
        sub_b = previous_edge_time;
      end
      ST_CMP_MIN: begin
        sub_a = interval;
        sub_b = cppm_pkg::TIME_W'(min_pulse_us);
      end
      ST_CMP_MAX: begin
        // max < interval means the interval is above the band
        sub_a = cppm_pkg::TIME_W'(max_pulse_us);
        sub_b = interval;
      end
      default: begin
        sub_a = interval;
        sub_b = cppm_pkg::TIME_W'(sync_pulse_us);
      end
    endcase
    sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
    sub_borrow = sub_res[cppm_pkg::TIME_W];
  end

  // short, or between band top and sync, is a bad interval
  assign bad           = lt_min | (gt_max & lt_sync);
  assign poisoned_next = poisoned | bad;
  assign out_free      = !out_valid || out_ready;
  assign in_ready      = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      min_pulse_us       <= cppm_pkg::RESET_MIN_PULSE;
      max_pulse_us       <= cppm_pkg::RESET_MAX_PULSE;
      sync_pulse_us      <= cppm_pkg::RESET_SYNC_PULSE;
      previous_edge_time <= '0;
      channel_position   <= '0;
      poisoned           <= 1'b0;
      bad_interval_count <= '0;
      out_valid          <= 1'b0;
      emit_idx           <= '0;
      for (int i = 0; i < cppm_pkg::CHANNELS; i++) begin
        pending_widths[i] <= cppm_pkg::RESET_WIDTH;
        held_widths[i]    <= cppm_pkg::RESET_WIDTH;
      end
    end else begin
      // configuration, the sender must keep writes to idle periods, the block does not enforce it
      if (cfg_write) begin
        unique case (cfg_index)
          cppm_pkg::REG_MIN_PULSE:  min_pulse_us  <= cfg_data;
          cppm_pkg::REG_MAX_PULSE:  max_pulse_us  <= cfg_data;
          cppm_pkg::REG_SYNC_PULSE: sync_pulse_us <= cfg_data;
          default: ;
        endcase
      end

      // output register drains on its own outside the burst, the emit state
      // refills or holds it itself
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            edge_time <= time_us;
            state     <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          // wrapping interval since the previous edge
          interval           <= sub_res[cppm_pkg::TIME_W-1:0];
          previous_edge_time <= edge_time;
          state              <= ST_CMP_MIN;
        end
        ST_CMP_MIN: begin
          lt_min <= sub_borrow;
          state  <= ST_CMP_MAX;
        end
        ST_CMP_MAX: begin
          gt_max <= sub_borrow;
          state  <= ST_CMP_SYNC;
        end
        ST_CMP_SYNC: begin
          lt_sync <= sub_borrow;
          state   <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (bad) begin
            bad_interval_count <= bad_interval_count + 1'b1;
          end
          if (!lt_sync) begin
            // frame sync: accept the pending set unless poisoned
            if (!poisoned_next) begin
              for (int i = 0; i < cppm_pkg::CHANNELS; i++) begin
                held_widths[i] <= pending_widths[i];
              end
            end
            burst_good       <= !poisoned_next;
            channel_position <= '0;
            poisoned         <= 1'b0;
            emit_idx         <= '0;
            state            <= ST_EMIT;
          end else begin
            poisoned <= poisoned_next;
            if (!poisoned_next &&
                (channel_position < cppm_pkg::POS_W'(cppm_pkg::CHANNELS))) begin
              pending_widths[channel_position[cppm_pkg::CHAN_IDX_W-1:0]] <=
                interval[cppm_pkg::WIDTH_W-1:0];
              channel_position <= channel_position + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          // one channel beat per free output slot
          if (out_free) begin
            out_valid   <= 1'b1;
            channel     <= cppm_pkg::CHANNEL_W'(emit_idx);
            width_us    <= held_widths[cppm_pkg::CHAN_IDX_W'(emit_idx)];
            last        <= (emit_idx == cppm_pkg::BURST_W'(cppm_pkg::BURST - 1));
            frame_good  <= burst_good;
            error_count <= bad_interval_count;
            if (emit_idx == cppm_pkg::BURST_W'(cppm_pkg::BURST - 1)) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // an accepted edge keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("edge accepted back to back");

  // a burst always begins afresh after its last beat is taken
  a_burst_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (!out_valid || (channel == '0)))
    else $error("channel beat after end of burst");

  // the error count only ever steps by one
  a_error_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(bad_interval_count) |->
      (bad_interval_count == cppm_pkg::WIDTH_W'($past(bad_interval_count) + 1'b1)))
    else $error("error count jumped");

  // a beat that is not the last has a channel below the burst end
  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |->
      (channel < cppm_pkg::CHANNEL_W'(cppm_pkg::BURST - 1)))
    else $error("last flag missing on final channel");

endmodule
